/* hdl/md5sh_pkg.sv */
// shared constants and tables for the md5 stream hasher
package md5sh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned StepW  = 6;
  localparam int unsigned WIdxW  = 4;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hefcdab89;
  localparam logic [WordW-1:0] InitC = 32'h98badcfe;
  localparam logic [WordW-1:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [1:0] RndF = 2'd0;
  localparam logic [1:0] RndG = 2'd1;
  localparam logic [1:0] RndH = 2'd2;
  localparam logic [1:0] RndI = 2'd3;

  // additive constant of each step
  function automatic logic [WordW-1:0] step_const(input logic [StepW-1:0] k);
    logic [WordW-1:0] r;
    case (k)
      6'd0:  r = 32'hd76aa478;  6'd1:  r = 32'he8c7b756;
      6'd2:  r = 32'h242070db;  6'd3:  r = 32'hc1bdceee;
      6'd4:  r = 32'hf57c0faf;  6'd5:  r = 32'h4787c62a;
      6'd6:  r = 32'ha8304613;  6'd7:  r = 32'hfd469501;
      6'd8:  r = 32'h698098d8;  6'd9:  r = 32'h8b44f7af;
      6'd10: r = 32'hffff5bb1;  6'd11: r = 32'h895cd7be;
      6'd12: r = 32'h6b901122;  6'd13: r = 32'hfd987193;
      6'd14: r = 32'ha679438e;  6'd15: r = 32'h49b40821;
      6'd16: r = 32'hf61e2562;  6'd17: r = 32'hc040b340;
      6'd18: r = 32'h265e5a51;  6'd19: r = 32'he9b6c7aa;
      6'd20: r = 32'hd62f105d;  6'd21: r = 32'h02441453;
      6'd22: r = 32'hd8a1e681;  6'd23: r = 32'he7d3fbc8;
      6'd24: r = 32'h21e1cde6;  6'd25: r = 32'hc33707d6;
      6'd26: r = 32'hf4d50d87;  6'd27: r = 32'h455a14ed;
      6'd28: r = 32'ha9e3e905;  6'd29: r = 32'hfcefa3f8;
      6'd30: r = 32'h676f02d9;  6'd31: r = 32'h8d2a4c8a;
      6'd32: r = 32'hfffa3942;  6'd33: r = 32'h8771f681;
      6'd34: r = 32'h6d9d6122;  6'd35: r = 32'hfde5380c;
      6'd36: r = 32'ha4beea44;  6'd37: r = 32'h4bdecfa9;
      6'd38: r = 32'hf6bb4b60;  6'd39: r = 32'hbebfbc70;
      6'd40: r = 32'h289b7ec6;  6'd41: r = 32'heaa127fa;
      6'd42: r = 32'hd4ef3085;  6'd43: r = 32'h04881d05;
      6'd44: r = 32'hd9d4d039;  6'd45: r = 32'he6db99e5;
      6'd46: r = 32'h1fa27cf8;  6'd47: r = 32'hc4ac5665;
      6'd48: r = 32'hf4292244;  6'd49: r = 32'h432aff97;
      6'd50: r = 32'hab9423a7;  6'd51: r = 32'hfc93a039;
      6'd52: r = 32'h655b59c3;  6'd53: r = 32'h8f0ccc92;
      6'd54: r = 32'hffeff47d;  6'd55: r = 32'h85845dd1;
      6'd56: r = 32'h6fa87e4f;  6'd57: r = 32'hfe2ce6e0;
      6'd58: r = 32'ha3014314;  6'd59: r = 32'h4e0811a1;
      6'd60: r = 32'hf7537e82;  6'd61: r = 32'hbd3af235;
      6'd62: r = 32'h2ad7d2bb;  6'd63: r = 32'heb86d391;
      default: r = '0;
    endcase
    return r;
  endfunction

  // left rotation of each step
  function automatic logic [4:0] step_rot(input logic [StepW-1:0] k);
    logic [4:0] r;
    case ({k[5:4], k[1:0]})
      4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
      4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
      4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
      4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
      default: r = 5'd7;
    endcase
    return r;
  endfunction

  // message word used by each step
  function automatic logic [WIdxW-1:0] msg_index(input logic [StepW-1:0] k);
    logic [WIdxW-1:0] ki;
    logic [WIdxW-1:0] r;
    ki = k[3:0];
    case (k[5:4])
      RndF:    r = ki;
      RndG:    r = WIdxW'(ki * 4'd5 + 4'd1);
      RndH:    r = WIdxW'(ki * 4'd3 + 4'd5);
      RndI:    r = WIdxW'(ki * 4'd7);
      default: r = ki;
    endcase
    return r;
  endfunction

endpackage

/* hdl/md5_stream_hasher.sv */
// md5 stream hasher: one message byte per item in, one 128-bit digest per message out
// a byte item is taken while idle; every 64th byte stalls the input while the block is compressed
// the end item then adds the padding of the final block and its compression
// (a second block when the length spills), and a load of the output register
// that load waits while the previous digest is unread; reset: chaining words to the initial
// vector, byte count to zero, no buffer clearing
module md5_stream_hasher
  import md5sh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tuser_i,   // has_byte
  input  logic         s_axis_tlast_i,   // last_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // digest_a, digest_b, digest_c, digest_d
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_CMP,
    S_ADD,
    S_OUT
  } state_e;

  state_e state_q;

  logic [WordW-1:0]  chain_a_q, chain_b_q, chain_c_q, chain_d_q;
  logic [WordW-1:0]  wa_q, wb_q, wc_q, wd_q, pre_q;
  logic [CountW-1:0] count_q;
  logic [WordW-1:0]  word_q;
  logic [StepW:0]    cnt_q;
  logic [WIdxW-1:0]  pw_q;
  logic              first_q, final_q, pad_q, last_q;
  logic              out_valid_q;
  logic [127:0]      out_data_q;

  logic [WordW-1:0]  mem_q [16];
  logic [WordW-1:0]  rdata_q;
  logic              mem_we;
  logic [WIdxW-1:0]  mem_waddr;
  logic [WordW-1:0]  mem_wdata;
  logic [WIdxW-1:0]  mem_raddr;

  logic              accept;
  logic [CountW-1:0] count_inc;
  logic [WordW-1:0]  word_ins;
  logic [WordW-1:0]  pad_word;
  logic [WordW-1:0]  pad_val;
  logic [StepW-1:0]  step_idx;
  logic [WordW-1:0]  step_b;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign count_inc = count_q + CountW'(1);
  assign step_idx  = StepW'(cnt_q - (StepW+1)'(1));
  assign mem_raddr = msg_index(cnt_q[StepW-1:0]);

  always_comb begin
    word_ins = word_q;
    word_ins[{count_q[1:0], 3'b000} +: 8] = s_axis_tdata_i;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < count_q[1:0]) begin
        pad_word[i*8 +: 8] = word_q[i*8 +: 8];
      end else if (2'(i) == count_q[1:0]) begin
        pad_word[i*8 +: 8] = PadByte;
      end else begin
        pad_word[i*8 +: 8] = 8'h00;
      end
    end
    if (first_q) begin
      pad_val = pad_word;
    end else if (final_q && pw_q == 4'd14) begin
      pad_val = {count_q[28:0], 3'b000};
    end else if (final_q && pw_q == 4'd15) begin
      pad_val = count_q[60:29];
    end else begin
      pad_val = '0;
    end
    if (state_q == S_PAD) begin
      mem_we    = 1'b1;
      mem_waddr = pw_q;
      mem_wdata = pad_val;
    end else begin
      mem_we    = accept && s_axis_tuser_i && (count_q[1:0] == 2'd3);
      mem_waddr = count_q[5:2];
      mem_wdata = word_ins;
    end
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  md5sh_step u_step (
    .step_i (step_idx),
    .b_i    (wb_q),
    .c_i    (wc_q),
    .d_i    (wd_q),
    .pre_i  (pre_q),
    .msg_i  (rdata_q),
    .b_o    (step_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chain_a_q   <= InitA;
      chain_b_q   <= InitB;
      chain_c_q   <= InitC;
      chain_d_q   <= InitD;
      count_q     <= '0;
      word_q      <= '0;
      wa_q        <= '0;
      wb_q        <= '0;
      wc_q        <= '0;
      wd_q        <= '0;
      pre_q       <= '0;
      cnt_q       <= '0;
      pw_q        <= '0;
      first_q     <= 1'b0;
      final_q     <= 1'b0;
      pad_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser_i) begin
              word_q  <= word_ins;
              count_q <= count_inc;
            end
            if (s_axis_tuser_i && count_inc[5:0] == 6'd0) begin
              // block full: compress, then pad if this item ends the message
              state_q <= S_CMP;
              cnt_q   <= '0;
              pad_q   <= 1'b0;
              last_q  <= s_axis_tlast_i;
              wa_q    <= chain_a_q;
              wb_q    <= chain_b_q;
              wc_q    <= chain_c_q;
              wd_q    <= chain_d_q;
              pre_q   <= chain_a_q + step_const('0);
            end else if (s_axis_tlast_i) begin
              state_q <= S_PAD;
              pad_q   <= 1'b1;
              first_q <= 1'b1;
              if (s_axis_tuser_i) begin
                pw_q    <= count_inc[5:2];
                final_q <= (count_inc[5:3] != 3'd7);
              end else begin
                pw_q    <= count_q[5:2];
                final_q <= (count_q[5:3] != 3'd7);
              end
            end
          end
        end
        S_PAD: begin
          first_q <= 1'b0;
          if (pw_q == 4'd15) begin
            state_q <= S_CMP;
            cnt_q   <= '0;
            wa_q    <= chain_a_q;
            wb_q    <= chain_b_q;
            wc_q    <= chain_c_q;
            wd_q    <= chain_d_q;
            pre_q   <= chain_a_q + step_const('0);
          end else begin
            pw_q <= pw_q + 4'd1;
          end
        end
        S_CMP: begin
          cnt_q <= cnt_q + (StepW+1)'(1);
          if (cnt_q != '0) begin
            wa_q  <= wd_q;
            wd_q  <= wc_q;
            wc_q  <= wb_q;
            wb_q  <= step_b;
            pre_q <= wd_q + step_const(cnt_q[StepW-1:0]);
          end
          if (cnt_q[StepW]) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          chain_a_q <= chain_a_q + wa_q;
          chain_b_q <= chain_b_q + wb_q;
          chain_c_q <= chain_c_q + wc_q;
          chain_d_q <= chain_d_q + wd_q;
          if (pad_q) begin
            if (final_q) begin
              state_q <= S_OUT;
            end else begin
              // length spills into a second padding block
              state_q <= S_PAD;
              final_q <= 1'b1;
              first_q <= 1'b0;
              pw_q    <= '0;
            end
          end else if (last_q) begin
            state_q <= S_PAD;
            pad_q   <= 1'b1;
            final_q <= 1'b1;
            first_q <= 1'b1;
            pw_q    <= '0;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {chain_d_q, chain_c_q, chain_b_q, chain_a_q};
            chain_a_q   <= InitA;
            chain_b_q   <= InitB;
            chain_c_q   <= InitC;
            chain_d_q   <= InitD;
            count_q     <= '0;
            pad_q       <= 1'b0;
            last_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/md5sh_step.sv */
// one md5 compression step: mixing function, add, rotate, add
module md5sh_step
  import md5sh_pkg::*;
(
  input  logic [StepW-1:0] step_i,
  input  logic [WordW-1:0] b_i,
  input  logic [WordW-1:0] c_i,
  input  logic [WordW-1:0] d_i,
  input  logic [WordW-1:0] pre_i,  // a plus step constant
  input  logic [WordW-1:0] msg_i,
  output logic [WordW-1:0] b_o
);

  logic [WordW-1:0]   mix;
  logic [WordW-1:0]   sum;
  logic [2*WordW-1:0] dbl;

  always_comb begin
    case (step_i[5:4])
      RndF:    mix = (b_i & c_i) | (~b_i & d_i);
      RndG:    mix = (b_i & d_i) | (c_i & ~d_i);
      RndH:    mix = b_i ^ c_i ^ d_i;
      RndI:    mix = c_i ^ (b_i | ~d_i);
      default: mix = b_i ^ c_i ^ d_i;
    endcase
    sum = pre_i + mix + msg_i;
    dbl = {sum, sum} << step_rot(step_i);
    b_o = b_i + dbl[2*WordW-1:WordW];
  end

endmodule

/* tb/sv/md5_digest_checker.sv */
// md5 digest checker: predicts each digest from the accepted byte items and compares it
module md5_digest_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tuser_i,   // has_byte
  input  logic         s_axis_tlast_i,   // last_byte
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [127:0] m_axis_tdata_i,   // digest_a, digest_b, digest_c, digest_d
  output int           fail_count_o,
  output int           pending_o,
  output int           digests_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] StartA  = 32'h67452301;
  localparam logic [31:0] StartB  = 32'hefcdab89;
  localparam logic [31:0] StartC  = 32'h98badcfe;
  localparam logic [31:0] StartD  = 32'h10325476;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam int          MaxShown = 40;

  localparam logic [31:0] RoundAdd [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int RotBy [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // word_a sits in the lowest bits, as on the result bus
  typedef struct packed {
    logic [31:0] word_d;
    logic [31:0] word_c;
    logic [31:0] word_b;
    logic [31:0] word_a;
  } digest_t;

  logic [31:0] hash_w [4];
  logic [31:0] blk_w [16];
  logic [60:0] byte_cnt;
  digest_t     pending_digests [$];
  int          fail_total;
  int          digest_total;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_chain();
    hash_w[0] = StartA;
    hash_w[1] = StartB;
    hash_w[2] = StartC;
    hash_w[3] = StartD;
    byte_cnt  = '0;
  endfunction

  function automatic void clear_block();
    for (int w = 0; w < 16; w++) blk_w[w] = '0;
  endfunction

  function automatic void put_byte(input logic [5:0] pos, input logic [7:0] val);
    blk_w[pos[5:2]][{pos[1:0], 3'b000} +: 8] = val;
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = hash_w[0];
    b = hash_w[1];
    c = hash_w[2];
    d = hash_w[3];
    for (int k = 0; k < 64; k++) begin
      case (k / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = k;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * k + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * k + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * k) % 16;
        end
      endcase
      t = a + f + RoundAdd[k] + blk_w[g];
      a = d;
      d = c;
      c = b;
      b = b + rotl(t, RotBy[(k / 16) * 4 + k % 4]);
    end
    hash_w[0] = hash_w[0] + a;
    hash_w[1] = hash_w[1] + b;
    hash_w[2] = hash_w[2] + c;
    hash_w[3] = hash_w[3] + d;
  endfunction

  // one accepted item: gather the byte, and on the end item pad and queue the digest
  function automatic void hash_item(input logic [7:0] data, input logic has, input logic fin);
    logic [5:0]  used;
    logic [63:0] bit_len;
    digest_t     dg;
    if (has) begin
      put_byte(byte_cnt[5:0], data);
      byte_cnt = byte_cnt + 1'b1;
      if (byte_cnt[5:0] == 6'd0) compress_block();
    end
    if (fin) begin
      used = byte_cnt[5:0];
      put_byte(used, PadMark);
      for (int p = used + 1; p < 64; p++) put_byte(6'(p), 8'h00);
      if (used >= 6'd56) begin
        compress_block();
        clear_block();
      end
      bit_len   = {byte_cnt, 3'b000};
      blk_w[14] = bit_len[31:0];
      blk_w[15] = bit_len[63:32];
      compress_block();
      dg.word_a = hash_w[0];
      dg.word_b = hash_w[1];
      dg.word_c = hash_w[2];
      dg.word_d = hash_w[3];
      pending_digests.push_back(dg);
      restart_chain();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_total < MaxShown) begin
      $display("%0t: %s: got %08h, want %08h", $time, what, got, want);
    end
    fail_total++;
  endtask

  task automatic check_digest(input logic [127:0] raw);
    digest_t got;
    digest_t want;
    got = raw;
    if (pending_digests.size() == 0) begin
      report_mismatch("digest item with none pending, word a", got.word_a, '0);
    end else begin
      want = pending_digests.pop_front();
      if (got.word_a !== want.word_a) report_mismatch("digest_a", got.word_a, want.word_a);
      if (got.word_b !== want.word_b) report_mismatch("digest_b", got.word_b, want.word_b);
      if (got.word_c !== want.word_c) report_mismatch("digest_c", got.word_c, want.word_c);
      if (got.word_d !== want.word_d) report_mismatch("digest_d", got.word_d, want.word_d);
      digest_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_chain();
      clear_block();
      pending_digests.delete();
      fail_total   = 0;
      digest_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      digests_o    <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        hash_item(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) check_digest(m_axis_tdata_i);
      fail_count_o <= fail_total;
      pending_o    <= pending_digests.size();
      digests_o    <= digest_total;
    end
  end

endmodule

/* tb/sv/tb_md5_stream_hasher.sv */
// testbench top for the md5 stream hasher: byte stimulus, result stalls and verdict
module tb_md5_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TargetItems = 1900;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 300;

  typedef enum logic [1:0] {RxFree, RxCoin, RxSparse, RxHold} rx_mode_e;
  typedef logic [7:0] byte_q_t [$];

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  int fail_count;
  int pending;
  int digests;

  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int          items_sent = 0;
  int          idle_sent = 0;
  int          msgs_sent = 0;
  int          bytes_sent = 0;
  int          spill_msgs = 0;
  int          longest = 0;
  int          cur_len = 0;
  rx_mode_e    rx_mode = RxFree;
  int unsigned rx_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  md5_stream_hasher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  md5_digest_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .digests_o       (digests)
  );

  // receiver stalls in randomly chosen modes: free, coin toss, sparse and hold
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxFree:   m_tready <= 1'b1;
      RxCoin:   m_tready <= ($urandom_range(0, 1) == 1);
      RxSparse: m_tready <= ($urandom_range(0, 3) == 0);
      default:  m_tready <= ((rx_left % 40) < 4);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d digests outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] data, input logic has, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has;
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (has || fin) items_sent++;
    else idle_sent++;
    if (has) begin
      bytes_sent++;
      cur_len++;
    end
    if (fin) begin
      msgs_sent++;
      if (cur_len > longest) longest = cur_len;
      if ((cur_len % 64) >= 56) spill_msgs++;
      cur_len = 0;
    end
  endtask

  task automatic send_bytes(input byte_q_t msg, input bit split_end, input bit with_idle);
    for (int i = 0; i < msg.size(); i++) begin
      if (with_idle && $urandom_range(0, 9) == 0) begin
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      push_item(msg[i], 1'b1, (i == msg.size() - 1) && !split_end);
    end
    if (msg.size() == 0 || split_end) begin
      push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    byte_q_t msg;
    byte_q_t none;
    int      len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    push_item(8'hff, 1'b0, 1'b0);
    send_bytes(none, 1'b1, 1'b0);
    send_bytes({8'h61, 8'h62, 8'h63}, 1'b0, 1'b0);
    send_bytes({8'h61}, 1'b1, 1'b0);
    send_bytes({8'hff}, 1'b0, 1'b0);
    send_bytes({8'h00}, 1'b0, 1'b0);
    // idle item inside a message, end item carrying an ignored byte
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b1);
    push_item(8'ha5, 1'b0, 1'b1);
    push_item(8'h3c, 1'b0, 1'b1);
    push_item(8'h80, 1'b1, 1'b1);
    drain_results();

    while (items_sent + idle_sent < TargetItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 8);
        4, 5, 6:    len = $urandom_range(50, 70);
        7, 8:       len = $urandom_range(0, 130);
        default:    len = $urandom_range(112, 128);
      endcase
      msg.delete();
      for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
      send_bytes(msg, $urandom_range(0, 1) == 1, 1'b1);
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d messages, %0d message bytes, %0d idle items",
             msgs_sent, bytes_sent, idle_sent);
    $display("%0d padding spills, longest %0d bytes, %0d digests compared under stalls",
             spill_msgs, longest, digests);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
